>>> rtl/slpg_pkg.sv
`default_nettype none

package slpg_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Every pattern color has full or zero components, so a color is a mask of lit components.
  typedef logic [2:0] mask_t;

  localparam mask_t MASK_BLACK  = 3'b000;
  localparam mask_t MASK_BLUE   = 3'b001;
  localparam mask_t MASK_GREEN  = 3'b010;
  localparam mask_t MASK_RED    = 3'b100;
  localparam mask_t MASK_YELLOW = 3'b110;
  localparam mask_t MASK_WHITE  = 3'b111;

  localparam logic [2:0] MODE_STARTUP       = 3'd0;
  localparam logic [2:0] MODE_WLAN_UP       = 3'd1;
  localparam logic [2:0] MODE_NOT_CONNECTED = 3'd2;
  localparam logic [2:0] MODE_CONNECTED     = 3'd3;
  localparam logic [2:0] MODE_CONNECTING    = 3'd4;
  localparam logic [2:0] MODE_WLAN_CONFIG   = 3'd5;
  localparam logic [2:0] MODE_PRE_RESET     = 3'd6;

  localparam logic [3:0] TALLY_OFF     = 4'd0;
  localparam logic [3:0] TALLY_PROGRAM = 4'd1;
  localparam logic [3:0] TALLY_PREVIEW = 4'd2;

  localparam logic CFG_PREVIEW_FRONT = 1'b0;
  localparam logic CFG_PREVIEW_BACK  = 1'b1;

  typedef logic [13:0] interval_t;

  localparam interval_t CHASE_STARTUP_MS     = 14'd100;
  localparam interval_t CHASE_WLAN_MS        = 14'd200;
  localparam interval_t BLINK_UNCONNECTED_MS = 14'd500;
  localparam interval_t CHASE_CONNECTING_MS  = 14'd500;
  localparam interval_t BLINK_CONFIG_MS      = 14'd2000;
  localparam interval_t BLINK_RESET_MS       = 14'd50;
  localparam interval_t BLINK_ERROR_MS       = 14'd200;
  localparam interval_t ALIVE_ON_MS          = 14'd100;
  localparam interval_t ALIVE_OFF_MS         = 14'd10000;
  localparam interval_t GAUGE_BLINK_MS       = 14'd1000;

  localparam logic [31:0] GAUGE_START_MS = 32'd200;
  localparam logic [6:0]  LEVEL_LIMIT    = 7'd99;
  localparam logic [6:0]  LEVEL_FULL     = 7'd100;
  localparam int          PERCENT_SPAN   = 100;
  localparam int          PAIR_LOW_LED   = 3;
  localparam int          PAIR_HIGH_LED  = 4;

  typedef enum logic [2:0] {
    BOP_NONE,
    BOP_CHASE,
    BOP_BLINK,
    BOP_ALIVE,
    BOP_FILL
  } back_op_t;

  typedef enum logic [1:0] {
    BK_FILL,
    BK_CHASE,
    BK_PAIR
  } back_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic strip;
  } dp_cmd_t;

  function automatic rgb_t scale_mask(mask_t m, logic [7:0] br);
    rgb_t c;
    c.red   = m[2] ? br : 8'd0;
    c.green = m[1] ? br : 8'd0;
    c.blue  = m[0] ? br : 8'd0;
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slpg_tick_if.sv
`default_nettype none

interface slpg_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic [2:0]  mode;
  logic [3:0]  tally_value;
  logic [7:0]  brightness;
  logic [6:0]  battery_percent;
  logic        charging;
  logic        usb_powered;
  logic        battery_window;

  modport source (
    output valid, time_ms, mode, tally_value, brightness, battery_percent,
           charging, usb_powered, battery_window,
    input  ready
  );

  modport sink (
    input  valid, time_ms, mode, tally_value, brightness, battery_percent,
           charging, usb_powered, battery_window,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/slpg_pixel_if.sv
`default_nettype none

interface slpg_pixel_if;
  logic       valid;
  logic       ready;
  logic       strip;
  logic [2:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;

  modport source (
    output valid, strip, led_index, red, green, blue, last,
    input  ready
  );

  modport sink (
    input  valid, strip, led_index, red, green, blue, last,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/slpg_ctrl.sv
`default_nettype none

module slpg_ctrl #(
  parameter int LED_COUNT = 8,
  parameter int IW        = $clog2(LED_COUNT)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tick_valid,
  output logic                   tick_ready,
  output logic                   pixel_valid,
  input  wire logic              pixel_ready,
  output slpg_pkg::dp_cmd_t      cmd,
  output logic [IW-1:0]          led,
  output logic                   last
);

  slpg_pkg::state_t state, state_next;
  logic             strip, strip_next;
  logic [IW-1:0]    led_next;
  logic             led_end;

  assign led_end = (led == IW'(LED_COUNT - 1));
  assign last    = strip && led_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slpg_pkg::ST_IDLE;
      strip <= 1'b0;
      led   <= '0;
    end else begin
      state <= state_next;
      strip <= strip_next;
      led   <= led_next;
    end
  end

  always_comb begin
    state_next  = state;
    strip_next  = strip;
    led_next    = led;
    tick_ready  = 1'b0;
    pixel_valid = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.strip   = strip;
    unique case (state)
      slpg_pkg::ST_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.load   = 1'b1;
          state_next = slpg_pkg::ST_EMIT;
          strip_next = 1'b0;
          led_next   = '0;
        end
      end
      slpg_pkg::ST_EMIT: begin
        pixel_valid = 1'b1;
        if (pixel_ready) begin
          cmd.advance = 1'b1;
          if (last) begin
            state_next = slpg_pkg::ST_IDLE;
          end else if (led_end) begin
            led_next   = '0;
            strip_next = 1'b1;
          end else begin
            led_next = led + IW'(1);
          end
        end
      end
      default: state_next = slpg_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/slpg_datapath.sv
`default_nettype none

module slpg_datapath #(
  parameter int LED_COUNT = 8,
  parameter int IW        = $clog2(LED_COUNT)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       time_ms,
  input  wire logic [2:0]        mode,
  input  wire logic [3:0]        tally_value,
  input  wire logic [7:0]        brightness,
  input  wire logic [6:0]        battery_percent,
  input  wire logic              charging,
  input  wire logic              usb_powered,
  input  wire logic              battery_window,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic              cfg_data,
  input  wire slpg_pkg::dp_cmd_t cmd,
  input  wire logic [IW-1:0]     led,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue
);

  localparam int PW = $clog2(slpg_pkg::PERCENT_SPAN * LED_COUNT + 1);

  logic                   preview_front;
  logic                   preview_back;

  logic [31:0]            back_deadline, back_deadline_next;
  logic                   back_phase, back_phase_next;
  logic [IW-1:0]          chase_pos, chase_pos_next;
  slpg_pkg::back_kind_t   back_kind, back_kind_next;
  slpg_pkg::rgb_t         back_color, back_color_next;
  logic [31:0]            front_deadline, front_deadline_next;
  logic                   front_phase, front_phase_next;

  logic                   gauge, gauge_next;
  logic                   gauge_blink, gauge_blink_next;
  logic [PW-1:0]          gauge_level, gauge_level_next;
  slpg_pkg::mask_t        front_mask, front_mask_next;
  logic [7:0]             br;
  logic [PW-1:0]          acc;

  slpg_pkg::back_op_t     back_op;
  slpg_pkg::interval_t    interval;
  slpg_pkg::mask_t        back_mask;
  logic                   back_fire;
  logic                   front_fire;
  logic [31:0]            back_sum;
  logic [6:0]             level;

  logic [PW-1:0]          acc_high;
  logic                   seg_on;
  slpg_pkg::rgb_t         front_px, back_px, px;

  // Decode mode and tally into one back strip operation and the front strip color.
  always_comb begin
    back_op         = slpg_pkg::BOP_NONE;
    interval        = '0;
    back_mask       = slpg_pkg::MASK_BLACK;
    front_mask_next = slpg_pkg::MASK_BLACK;
    unique case (mode)
      slpg_pkg::MODE_STARTUP: begin
        back_op   = slpg_pkg::BOP_CHASE;
        interval  = slpg_pkg::CHASE_STARTUP_MS;
        back_mask = slpg_pkg::MASK_BLUE;
      end
      slpg_pkg::MODE_WLAN_UP: begin
        back_op   = slpg_pkg::BOP_CHASE;
        interval  = slpg_pkg::CHASE_WLAN_MS;
        back_mask = slpg_pkg::MASK_BLUE;
      end
      slpg_pkg::MODE_NOT_CONNECTED: begin
        back_op   = slpg_pkg::BOP_BLINK;
        interval  = slpg_pkg::BLINK_UNCONNECTED_MS;
        back_mask = slpg_pkg::MASK_BLUE;
      end
      slpg_pkg::MODE_CONNECTING: begin
        back_op   = slpg_pkg::BOP_CHASE;
        interval  = slpg_pkg::CHASE_CONNECTING_MS;
        back_mask = slpg_pkg::MASK_BLUE;
      end
      slpg_pkg::MODE_WLAN_CONFIG: begin
        back_op   = slpg_pkg::BOP_BLINK;
        interval  = slpg_pkg::BLINK_CONFIG_MS;
        back_mask = slpg_pkg::MASK_BLUE;
      end
      slpg_pkg::MODE_PRE_RESET: begin
        back_op   = slpg_pkg::BOP_BLINK;
        interval  = slpg_pkg::BLINK_RESET_MS;
        back_mask = slpg_pkg::MASK_RED;
      end
      slpg_pkg::MODE_CONNECTED: begin
        priority if (tally_value == slpg_pkg::TALLY_OFF) begin
          back_op  = slpg_pkg::BOP_ALIVE;
          interval = back_phase ? slpg_pkg::ALIVE_OFF_MS : slpg_pkg::ALIVE_ON_MS;
        end else if (tally_value == slpg_pkg::TALLY_PROGRAM) begin
          back_op         = slpg_pkg::BOP_FILL;
          back_mask       = slpg_pkg::MASK_RED;
          front_mask_next = slpg_pkg::MASK_RED;
        end else if (tally_value == slpg_pkg::TALLY_PREVIEW) begin
          back_op         = slpg_pkg::BOP_FILL;
          back_mask       = preview_back ? slpg_pkg::MASK_GREEN : slpg_pkg::MASK_BLACK;
          front_mask_next = preview_front ? slpg_pkg::MASK_GREEN : slpg_pkg::MASK_BLACK;
        end else begin
          back_op   = slpg_pkg::BOP_BLINK;
          interval  = slpg_pkg::BLINK_ERROR_MS;
          back_mask = slpg_pkg::MASK_RED;
        end
      end
      default: back_op = slpg_pkg::BOP_NONE;
    endcase
  end

  assign back_fire = (back_deadline < time_ms);
  assign back_sum  = time_ms + 32'(interval);

  always_comb begin
    back_deadline_next = back_deadline;
    back_phase_next    = back_phase;
    chase_pos_next     = chase_pos;
    back_kind_next     = back_kind;
    back_color_next    = back_color;
    unique case (back_op)
      slpg_pkg::BOP_CHASE: begin
        if (back_fire) begin
          chase_pos_next     = (chase_pos == IW'(LED_COUNT - 1)) ? '0 : chase_pos + IW'(1);
          back_deadline_next = back_sum;
        end
        back_kind_next  = slpg_pkg::BK_CHASE;
        back_color_next = slpg_pkg::scale_mask(back_mask, brightness);
      end
      slpg_pkg::BOP_BLINK: begin
        if (back_fire) begin
          back_phase_next    = !back_phase;
          back_deadline_next = back_sum;
        end
        back_kind_next  = slpg_pkg::BK_FILL;
        back_color_next = slpg_pkg::scale_mask(
            back_phase_next ? back_mask : slpg_pkg::MASK_BLACK, brightness);
      end
      slpg_pkg::BOP_ALIVE: begin
        if (back_fire) begin
          back_phase_next    = !back_phase;
          back_deadline_next = back_sum;
          if (!back_phase) begin
            back_kind_next  = slpg_pkg::BK_PAIR;
            back_color_next = slpg_pkg::scale_mask(slpg_pkg::MASK_WHITE, brightness);
          end else begin
            back_kind_next  = slpg_pkg::BK_FILL;
            back_color_next = '0;
          end
        end
      end
      slpg_pkg::BOP_FILL: begin
        back_kind_next  = slpg_pkg::BK_FILL;
        back_color_next = slpg_pkg::scale_mask(back_mask, brightness);
      end
      default: back_kind_next = back_kind;
    endcase
  end

  assign gauge_next = (time_ms > slpg_pkg::GAUGE_START_MS) && (usb_powered || battery_window);
  assign front_fire = gauge_next && (front_deadline < time_ms);

  always_comb begin
    front_deadline_next = front_deadline;
    front_phase_next    = front_phase;
    if (front_fire) begin
      front_phase_next    = !front_phase;
      front_deadline_next = time_ms + 32'(slpg_pkg::GAUGE_BLINK_MS);
    end
  end

  always_comb begin
    if (charging || !usb_powered) begin
      level = (battery_percent < slpg_pkg::LEVEL_LIMIT) ? battery_percent : slpg_pkg::LEVEL_LIMIT;
    end else begin
      level = slpg_pkg::LEVEL_FULL;
    end
  end

  // The gauge level is kept as percent times LED count, so no division is needed.
  assign gauge_level_next = PW'(level) * PW'(LED_COUNT);
  assign gauge_blink_next = front_phase_next && charging;

  always_ff @(posedge clk) begin
    if (rst) begin
      preview_front  <= 1'b0;
      preview_back   <= 1'b1;
      back_deadline  <= '0;
      back_phase     <= 1'b0;
      chase_pos      <= '0;
      back_kind      <= slpg_pkg::BK_FILL;
      back_color     <= '0;
      front_deadline <= '0;
      front_phase    <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == slpg_pkg::CFG_PREVIEW_FRONT) begin
          preview_front <= cfg_data;
        end else begin
          preview_back <= cfg_data;
        end
      end
      if (cmd.load) begin
        back_deadline  <= back_deadline_next;
        back_phase     <= back_phase_next;
        chase_pos      <= chase_pos_next;
        back_kind      <= back_kind_next;
        back_color     <= back_color_next;
        front_deadline <= front_deadline_next;
        front_phase    <= front_phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gauge       <= gauge_next;
      gauge_blink <= gauge_blink_next;
      gauge_level <= gauge_level_next;
      front_mask  <= front_mask_next;
      br          <= brightness;
      acc         <= '0;
    end else if (cmd.advance && !cmd.strip) begin
      acc <= acc_high;
    end
  end

  // The accumulator holds the LED position times one hundred for the front strip.
  assign acc_high = acc + PW'(slpg_pkg::PERCENT_SPAN);
  assign seg_on   = (acc_high <= gauge_level)
                 || ((acc <= gauge_level) && (gauge_level < acc_high) && gauge_blink);

  always_comb begin
    if (gauge) begin
      front_px = slpg_pkg::scale_mask(seg_on ? slpg_pkg::MASK_YELLOW : slpg_pkg::MASK_BLACK, br);
    end else begin
      front_px = slpg_pkg::scale_mask(front_mask, br);
    end
  end

  always_comb begin
    unique case (back_kind)
      slpg_pkg::BK_FILL:  back_px = back_color;
      slpg_pkg::BK_CHASE: back_px = (led == chase_pos) ? back_color : '0;
      slpg_pkg::BK_PAIR:  back_px = ((led == IW'(slpg_pkg::PAIR_LOW_LED))
                                  || (led == IW'(slpg_pkg::PAIR_HIGH_LED))) ? back_color : '0;
      default:            back_px = '0;
    endcase
  end

  assign px    = cmd.strip ? back_px : front_px;
  assign red   = px.red;
  assign green = px.green;
  assign blue  = px.blue;

endmodule

`default_nettype wire

>>> rtl/status_led_pattern_generator_unit.sv
// Status LED pattern generator for a front and a back LED strip.
// The tick channel takes one word per display refresh: time, device mode, tally value,
// brightness and battery state. The pixel channel returns 2*LED_COUNT words per tick,
// first every front strip LED, then every back strip LED, with last set on the final one.
// Configuration writes (cfg_write, cfg_index, cfg_data) set the preview enables and take
// effect on the next tick; write only while no tick is in progress.
// A tick is accepted only while the block is idle. The accept edge updates the pattern
// timers, chase position and back strip pattern; the first pixel word is valid on the
// following cycle and one word is sent per cycle while the receiver takes them.
// A tick passes the state update, then the pixel sequencer with one word per LED.
// When the receiver stalls, the current word holds and the sequencer waits; no word is
// dropped or repeated. Synchronous reset clears the timers, the chase position, the back
// strip to black and the preview enables to their defaults (front off, back on).
`default_nettype none

module status_led_pattern_generator_unit #(
  parameter int LED_COUNT = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  slpg_tick_if.sink     tick,
  slpg_pixel_if.source  pixel,
  input  wire logic     cfg_write,
  input  wire logic     cfg_index,
  input  wire logic     cfg_data
);

  localparam int IW = $clog2(LED_COUNT);

  slpg_pkg::dp_cmd_t cmd;
  logic [IW-1:0]     led;

  slpg_ctrl #(
    .LED_COUNT (LED_COUNT),
    .IW        (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .cmd         (cmd),
    .led         (led),
    .last        (pixel.last)
  );

  slpg_datapath #(
    .LED_COUNT (LED_COUNT),
    .IW        (IW)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .time_ms         (tick.time_ms),
    .mode            (tick.mode),
    .tally_value     (tick.tally_value),
    .brightness      (tick.brightness),
    .battery_percent (tick.battery_percent),
    .charging        (tick.charging),
    .usb_powered     (tick.usb_powered),
    .battery_window  (tick.battery_window),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .led             (led),
    .red             (pixel.red),
    .green           (pixel.green),
    .blue            (pixel.blue)
  );

  assign pixel.strip     = cmd.strip;
  assign pixel.led_index = led[2:0];

endmodule

`default_nettype wire

>>> rtl/slpg_checker.sv
`default_nettype none

module slpg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       tick_valid,
  input wire logic       tick_ready,
  input wire logic       pixel_valid,
  input wire logic       pixel_ready,
  input wire logic       pixel_strip,
  input wire logic [2:0] pixel_led_index,
  input wire logic [7:0] pixel_red,
  input wire logic [7:0] pixel_green,
  input wire logic [7:0] pixel_blue,
  input wire logic       pixel_last
);

  logic tick_take;
  logic pixel_take;

  assign tick_take  = tick_valid && tick_ready;
  assign pixel_take = pixel_valid && pixel_ready;

  a_no_tick_while_emitting: assert property (@(posedge clk) disable iff (rst)
    tick_ready |-> !pixel_valid)
    else $error("tick ready while pixel words are pending");

  a_first_word_after_tick: assert property (@(posedge clk) disable iff (rst)
    tick_take |=> (pixel_valid && !pixel_strip && (pixel_led_index == 3'd0)))
    else $error("first word after a tick is not front LED zero");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (pixel_take && pixel_last) |=> (tick_ready && !pixel_valid))
    else $error("block not idle after the last word");

  a_back_index_steps: assert property (@(posedge clk) disable iff (rst)
    (pixel_take && pixel_strip && !pixel_last) |=>
      (pixel_valid && pixel_strip && (pixel_led_index == $past(pixel_led_index) + 3'd1)))
    else $error("back strip LED index did not advance by one");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=>
      (pixel_valid && $stable(pixel_red) && $stable(pixel_green) && $stable(pixel_blue)
       && $stable(pixel_led_index) && $stable(pixel_last)))
    else $error("stalled pixel word changed");

endmodule

bind status_led_pattern_generator_unit slpg_checker u_slpg_checker (
  .clk             (clk),
  .rst             (rst),
  .tick_valid      (tick.valid),
  .tick_ready      (tick.ready),
  .pixel_valid     (pixel.valid),
  .pixel_ready     (pixel.ready),
  .pixel_strip     (pixel.strip),
  .pixel_led_index (pixel.led_index),
  .pixel_red       (pixel.red),
  .pixel_green     (pixel.green),
  .pixel_blue      (pixel.blue),
  .pixel_last      (pixel.last)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int LEDS = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PERCENT = 19;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 50;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [3:0] TALLY_ERR_LOW = 4'd3;
  localparam logic [3:0] TALLY_ERR_MID = 4'd9;
  localparam logic [3:0] TALLY_ERR_TOP = 4'd15;

  localparam logic [23:0] RGB_BLACK  = 24'h000000;
  localparam logic [23:0] RGB_RED    = 24'hFF0000;
  localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
  localparam logic [23:0] RGB_BLUE   = 24'h0000FF;
  localparam logic [23:0] RGB_YELLOW = 24'hFFFF00;
  localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [2:0]  mode;
    logic [3:0]  tally_value;
    logic [7:0]  brightness;
    logic [6:0]  battery_percent;
    logic        charging;
    logic        usb_powered;
    logic        battery_window;
  } tick_t;

  typedef struct packed {
    tick_t       word;
    logic        typed;
    logic [23:0] front_rgb;
    logic [23:0] back_rgb;
  } plan_row_t;

  typedef struct packed {
    logic            strip;
    logic [2:0]      led_index;
    slpg_pkg::rgb_t  color;
    logic            last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic cfg_index;
  logic cfg_data;

  slpg_tick_if  tick_bus ();
  slpg_pixel_if pixel_bus ();

  status_led_pattern_generator_unit #(
    .LED_COUNT(LEDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .tick(tick_bus),
    .pixel(pixel_bus),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Model of the block: pattern timers, chase position, back strip and preview enables.
  logic [31:0]    strip_deadline;
  logic           strip_phase;
  logic [2:0]     chase_at;
  slpg_pkg::rgb_t back_strip [LEDS];
  logic [31:0]    gauge_deadline;
  logic           gauge_phase;
  logic           preview_front_on;
  logic           preview_back_on;
  slpg_pkg::rgb_t front_frame [LEDS];

  pixel_t      pending_pixels [$];
  logic [31:0] now_ms;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          hold_requests = 0;
  logic        tick_gaps_on = 1'b1;
  logic        pixel_stalls_on = 1'b1;

  function automatic slpg_pkg::rgb_t shade(logic [23:0] color, logic [7:0] br);
    slpg_pkg::rgb_t c;
    c.red   = 8'(int'(color[23:16]) * int'(br) / 255);
    c.green = 8'(int'(color[15:8]) * int'(br) / 255);
    c.blue  = 8'(int'(color[7:0]) * int'(br) / 255);
    return c;
  endfunction

  task automatic fill_back(logic [23:0] color, logic [7:0] br);
    int i;
    for (i = 0; i < LEDS; i++) back_strip[i] = shade(color, br);
  endtask

  task automatic run_chase(logic [31:0] t, logic [23:0] color, logic [31:0] period,
                           logic [7:0] br);
    int i;
    if (strip_deadline < t) begin
      chase_at = chase_at + 3'd1;
      strip_deadline = t + period;
    end
    for (i = 0; i < LEDS; i++) back_strip[i] = (i == chase_at) ? shade(color, br) : '0;
  endtask

  task automatic run_blink(logic [31:0] t, logic [23:0] color, logic [31:0] period,
                           logic [7:0] br);
    if (strip_deadline < t) begin
      strip_phase = !strip_phase;
      strip_deadline = t + period;
    end
    fill_back(strip_phase ? color : RGB_BLACK, br);
  endtask

  task automatic run_alive(logic [31:0] t, logic [7:0] br);
    if (strip_deadline < t) begin
      strip_phase = !strip_phase;
      fill_back(RGB_BLACK, br);
      if (strip_phase) begin
        strip_deadline = t + 32'd100;
        back_strip[3] = shade(RGB_WHITE, br);
        back_strip[4] = shade(RGB_WHITE, br);
      end else begin
        strip_deadline = t + 32'd10000;
      end
    end
  endtask

  task automatic compute_frame(input tick_t w);
    logic [23:0] front_color;
    logic [6:0]  level;
    int          lit;
    int          i;
    front_color = RGB_BLACK;
    case (w.mode)
      slpg_pkg::MODE_STARTUP:
        run_chase(w.time_ms, RGB_BLUE, 32'd100, w.brightness);
      slpg_pkg::MODE_WLAN_UP:
        run_chase(w.time_ms, RGB_BLUE, 32'd200, w.brightness);
      slpg_pkg::MODE_NOT_CONNECTED:
        run_blink(w.time_ms, RGB_BLUE, 32'd500, w.brightness);
      slpg_pkg::MODE_CONNECTING:
        run_chase(w.time_ms, RGB_BLUE, 32'd500, w.brightness);
      slpg_pkg::MODE_WLAN_CONFIG:
        run_blink(w.time_ms, RGB_BLUE, 32'd2000, w.brightness);
      slpg_pkg::MODE_PRE_RESET:
        run_blink(w.time_ms, RGB_RED, 32'd50, w.brightness);
      slpg_pkg::MODE_CONNECTED: begin
        if (w.tally_value == slpg_pkg::TALLY_OFF) begin
          run_alive(w.time_ms, w.brightness);
        end else if (w.tally_value == slpg_pkg::TALLY_PROGRAM) begin
          front_color = RGB_RED;
          fill_back(RGB_RED, w.brightness);
        end else if (w.tally_value == slpg_pkg::TALLY_PREVIEW) begin
          front_color = preview_front_on ? RGB_GREEN : RGB_BLACK;
          fill_back(preview_back_on ? RGB_GREEN : RGB_BLACK, w.brightness);
        end else begin
          run_blink(w.time_ms, RGB_RED, 32'd200, w.brightness);
        end
      end
      default: ;
    endcase
    for (i = 0; i < LEDS; i++) front_frame[i] = shade(front_color, w.brightness);
    if (w.time_ms > 32'd200 && (w.usb_powered || w.battery_window)) begin
      if (gauge_deadline < w.time_ms) begin
        gauge_phase = !gauge_phase;
        gauge_deadline = w.time_ms + 32'd1000;
      end
      if (w.charging || !w.usb_powered) begin
        level = (w.battery_percent < 7'd99) ? w.battery_percent : 7'd99;
      end else begin
        level = 7'd100;
      end
      lit = int'(level) * LEDS / 100;
      for (i = 0; i < LEDS; i++) begin
        front_frame[i] = shade(((i < lit) || (i == lit && gauge_phase && w.charging)) ?
                               RGB_YELLOW : RGB_BLACK, w.brightness);
      end
    end
  endtask

  function automatic plan_row_t row(logic [31:0] t, logic [2:0] m, logic [3:0] tv,
                                    logic [7:0] br, logic [6:0] pct, logic chg, logic usb,
                                    logic win, logic typed = 1'b0,
                                    logic [23:0] f = RGB_BLACK, logic [23:0] b = RGB_BLACK);
    plan_row_t r;
    r.word = '{t, m, tv, br, pct, chg, usb, win};
    r.typed = typed;
    r.front_rgb = f;
    r.back_rgb = b;
    return r;
  endfunction

  function automatic plan_row_t random_row();
    plan_row_t r;
    int pick;
    r = '0;
    pick = $urandom_range(99);
    if (pick < 4) begin
      now_ms = $urandom;
    end else if (pick < 9) begin
      now_ms = now_ms + $urandom_range(12000, 9000);
    end else begin
      now_ms = now_ms + $urandom_range(400);
    end
    r.word.time_ms = now_ms;
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.word.mode = slpg_pkg::MODE_CONNECTED;
    end else if (pick < 50) begin
      r.word.mode = MODE_UNUSED;
    end else begin
      r.word.mode = 3'($urandom_range(slpg_pkg::MODE_PRE_RESET));
    end
    if ($urandom_range(99) < 85) begin
      r.word.tally_value = 4'($urandom_range(slpg_pkg::TALLY_PREVIEW));
    end else begin
      r.word.tally_value = 4'($urandom_range(TALLY_ERR_TOP, TALLY_ERR_LOW));
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.word.brightness = 8'd0;
    end else if (pick < 20) begin
      r.word.brightness = 8'd255;
    end else begin
      r.word.brightness = 8'($urandom);
    end
    if ($urandom_range(99) < 85) begin
      r.word.battery_percent = 7'($urandom_range(100));
    end else begin
      r.word.battery_percent = 7'($urandom_range(127));
    end
    r.word.charging = 1'($urandom);
    r.word.usb_powered = 1'($urandom);
    r.word.battery_window = 1'($urandom);
    return r;
  endfunction

  // Starts and ends at a falling edge; the word stays on the bus until a later call.
  task automatic offer_tick(input plan_row_t r);
    pixel_t px;
    int s;
    int i;
    while (tick_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      tick_bus.valid = 1'b0;
      @(negedge clk);
    end
    tick_bus.time_ms = r.word.time_ms;
    tick_bus.mode = r.word.mode;
    tick_bus.tally_value = r.word.tally_value;
    tick_bus.brightness = r.word.brightness;
    tick_bus.battery_percent = r.word.battery_percent;
    tick_bus.charging = r.word.charging;
    tick_bus.usb_powered = r.word.usb_powered;
    tick_bus.battery_window = r.word.battery_window;
    tick_bus.valid = 1'b1;
    do @(posedge clk); while (tick_bus.ready !== 1'b1);
    compute_frame(r.word);
    for (s = 0; s < 2; s++) begin
      for (i = 0; i < LEDS; i++) begin
        px.strip = 1'(s);
        px.led_index = 3'(i);
        if (r.typed) begin
          px.color = (s == 1) ? r.back_rgb : r.front_rgb;
        end else begin
          px.color = (s == 1) ? back_strip[i] : front_frame[i];
        end
        px.last = (s == 1 && i == LEDS - 1);
        pending_pixels.push_back(px);
      end
    end
    @(negedge clk);
  endtask

  task automatic write_preview(input logic front_on, input logic back_on);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = slpg_pkg::CFG_PREVIEW_FRONT;
    cfg_data = front_on;
    @(negedge clk);
    cfg_index = slpg_pkg::CFG_PREVIEW_BACK;
    cfg_data = back_on;
    @(negedge clk);
    cfg_write = 1'b0;
    preview_front_on = front_on;
    preview_back_on = back_on;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : pixel_monitor
    pixel_t want;
    if (!rst && pixel_bus.valid === 1'b1 && pixel_bus.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word: strip %0d led %0d", pixel_bus.strip,
               pixel_bus.led_index);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("strip", want.strip, pixel_bus.strip);
        compare_field("led_index", want.led_index, pixel_bus.led_index);
        compare_field("red", want.color.red, pixel_bus.red);
        compare_field("green", want.color.green, pixel_bus.green);
        compare_field("blue", want.color.blue, pixel_bus.blue);
        compare_field("last", want.last, pixel_bus.last);
      end
    end
  end

  // During a hold-off the receiver refuses every word, so the block holds its current word.
  initial begin : pixel_receiver
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    pixel_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel_bus.ready = 1'b0;
      end else if (pixel_stalls_on) begin
        pixel_bus.ready = ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
        pixel_bus.ready = 1'b1;
      end
    end
  end

  initial begin : main_sequence
    plan_row_t plan [$];
    int phase;
    int i;
    tick_bus.valid = 1'b0;
    tick_bus.time_ms = '0;
    tick_bus.mode = slpg_pkg::MODE_STARTUP;
    tick_bus.tally_value = slpg_pkg::TALLY_OFF;
    tick_bus.brightness = '0;
    tick_bus.battery_percent = '0;
    tick_bus.charging = 1'b0;
    tick_bus.usb_powered = 1'b0;
    tick_bus.battery_window = 1'b0;
    cfg_write = 1'b0;
    cfg_index = slpg_pkg::CFG_PREVIEW_FRONT;
    cfg_data = 1'b0;
    strip_deadline = '0;
    strip_phase = 1'b0;
    chase_at = '0;
    for (i = 0; i < LEDS; i++) back_strip[i] = '0;
    gauge_deadline = '0;
    gauge_phase = 1'b0;
    preview_front_on = 1'b0;
    preview_back_on = 1'b1;
    now_ms = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    plan = '{
      row(100, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_PROGRAM,
          255, 0, 0, 0, 0, 1, RGB_RED, RGB_RED),
      row(150, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_PROGRAM,
          0, 0, 0, 0, 0, 1, RGB_BLACK, RGB_BLACK),
      row(180, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_PREVIEW,
          255, 0, 0, 0, 0, 1, RGB_BLACK, RGB_GREEN),
      row(190, MODE_UNUSED, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(1000, slpg_pkg::MODE_CONNECTED, TALLY_ERR_MID,
          255, 0, 0, 0, 0, 1, RGB_BLACK, RGB_RED),
      row(1100, slpg_pkg::MODE_CONNECTED, TALLY_ERR_TOP, 128, 0, 0, 0, 0),
      row(1300, slpg_pkg::MODE_CONNECTED, TALLY_ERR_LOW, 255, 0, 0, 0, 0),
      row(1400, slpg_pkg::MODE_STARTUP, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(1600, slpg_pkg::MODE_STARTUP, slpg_pkg::TALLY_OFF, 200, 0, 0, 0, 0),
      row(2000, slpg_pkg::MODE_WLAN_UP, slpg_pkg::TALLY_PROGRAM, 255, 0, 0, 0, 0),
      row(3000, slpg_pkg::MODE_NOT_CONNECTED, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(4000, slpg_pkg::MODE_CONNECTING, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(7000, slpg_pkg::MODE_WLAN_CONFIG, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(7100, slpg_pkg::MODE_PRE_RESET, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(20000, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(20050, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_OFF, 77, 0, 0, 0, 0),
      row(20200, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(30300, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_OFF, 255, 0, 0, 0, 0),
      row(5000, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_PROGRAM, 255, 50, 1, 1, 0),
      row(201, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_OFF, 255, 127, 0, 0, 1),
      row(200, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_PROGRAM, 255, 100, 1, 1, 1),
      row(6000, slpg_pkg::MODE_CONNECTED, slpg_pkg::TALLY_PREVIEW, 255, 30, 0, 1, 0),
      row(32'hFFFF_FFFF, slpg_pkg::MODE_STARTUP, slpg_pkg::TALLY_OFF, 255, 100, 1, 1, 1),
      row(0, slpg_pkg::MODE_PRE_RESET, slpg_pkg::TALLY_OFF, 255, 0, 1, 1, 1),
      row(7000, slpg_pkg::MODE_CONNECTED, TALLY_ERR_LOW, 255, 99, 1, 0, 1)
    };
    foreach (plan[k]) offer_tick(plan[k]);
    tick_bus.valid = 1'b0;
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      if (phase == 1) hold_requests++;
      tick_gaps_on = (phase != 2);
      pixel_stalls_on = (phase != 2);
      write_preview(phase < 2, phase % 3 == 0);
      now_ms = '0;
      repeat (ITEMS_PER_PHASE) offer_tick(random_row());
      tick_bus.valid = 1'b0;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
